@@ design/dimmer_serial_message_parser_unit_assert.svh @@
// assertion macros for the dimmer serial message parser
`ifndef DIMMER_SERIAL_MESSAGE_PARSER_UNIT_ASSERT_SVH
`define DIMMER_SERIAL_MESSAGE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DSMP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsmp assertion failed (same cycle)");

// next-cycle implication, disabled while reset is asserted
`define DSMP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsmp assertion failed (next cycle)");

`endif

@@ design/dsmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dsmp_pkg;

    localparam logic [7:0] C_TERM     = 8'h1B;
    localparam logic [6:0] BRIGHT_MAX = 7'd100;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_RESULT = 3'd1,
        KIND_UPDATE = 3'd2,
        KIND_ENTER  = 3'd3,
        KIND_EXIT   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_AWAIT_KEY = 2'd0,
        PH_KEY       = 2'd1,
        PH_AWAIT_VAL = 2'd2,
        PH_VALUE     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KEY_NONE      = 2'd0,
        KEY_SWITCH    = 2'd1,
        KEY_BRIGHT    = 2'd2,
        KEY_UNDECIDED = 2'd3
    } t_key;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       cur_switch;
        logic [6:0] cur_bright;
    } t_item;

    typedef struct packed {
        t_kind      msg_kind;
        logic       send_ok;
        logic       switch_change;
        logic       new_switch;
        logic       bright_change;
        logic [6:0] new_bright;
    } t_result;

endpackage

`default_nettype wire

@@ design/dimmer_serial_message_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// dimmer serial message parser
// input channel: one received serial byte per transfer (i_rx_byte) together
//   with the current light state (i_cur_switch, i_cur_bright), which only
//   matters on the terminator byte 0x1B
// output channel: one result transfer per terminator byte, none for any other
//   byte; carries the message kind, the ok-reply request and the new state
// path: a terminator passes the input register, then the result register, before
//   its result shows on o_out_valid
// throughput: one byte per cycle when not stalled; each byte updates the parse
//   state with a single pass of match and digit logic between the two registers
// reset: empties both registers, drops any partial message and leaves
//   settings mode
// receiver stall: the result register holds its transfer; ordinary bytes keep
//   flowing, a terminator waits in the input register and o_in_stall rises
//   until the held result is taken

module dimmer_serial_message_parser_unit
    import dsmp_pkg::*;
#(
    parameter int BUFFER_LEN = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cur_switch,
    input  wire logic [6:0] i_cur_bright,

    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_msg_kind,
    output logic            o_send_ok,
    output logic            o_switch_change,
    output logic            o_new_switch,
    output logic            o_bright_change,
    output logic [6:0]      o_new_bright
);

    t_item   s_item_in;
    t_item   s_item_held;
    logic    s_held_valid;
    logic    s_held_term;
    logic    s_out_busy;
    logic    s_fire;
    logic    s_res_load;
    t_result s_res_next;
    t_result s_res_out;

    assign s_item_in = '{rx_byte: i_rx_byte, cur_switch: i_cur_switch,
                         cur_bright: i_cur_bright};

    // input register, holds one byte ahead of the parser
    dsmp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (s_item_in),
        .i_fire  (s_fire),
        .o_stall (o_in_stall),
        .o_valid (s_held_valid),
        .o_item  (s_item_held)
    );

    // a terminator may only move when the result register can take it;
    // every other byte moves whenever one is held
    assign s_held_term = (s_item_held.rx_byte == C_TERM);
    assign s_fire      = s_held_valid && !(s_held_term && s_out_busy);
    assign s_res_load  = s_fire && s_held_term;

    // message state and classification
    dsmp_parser #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s_fire),
        .i_item  (s_item_held),
        .o_res   (s_res_next)
    );

    // result register, parts the parser from the receiver
    dsmp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_res_load),
        .i_res   (s_res_next),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_busy  (s_out_busy),
        .o_res   (s_res_out)
    );

    assign o_msg_kind      = s_res_out.msg_kind;
    assign o_send_ok       = s_res_out.send_ok;
    assign o_switch_change = s_res_out.switch_change;
    assign o_new_switch    = s_res_out.new_switch;
    assign o_bright_change = s_res_out.bright_change;
    assign o_new_bright    = s_res_out.new_bright;

    `include "dimmer_serial_message_parser_unit_assert.svh"

    // only update results carry change flags or an ok request
    `DSMP_ASSERT_IMPL(a_flags_only_on_update, i_clk, i_rst_n, o_out_valid && (o_msg_kind != KIND_UPDATE), !o_send_ok && !o_switch_change && !o_bright_change)

    // ok is requested exactly when the brightness stays
    `DSMP_ASSERT_IMPL(a_ok_iff_bright_same, i_clk, i_rst_n, o_out_valid && (o_msg_kind == KIND_UPDATE), o_send_ok == !o_bright_change)

    // the input side waits only behind a terminator blocked by a held result
    `DSMP_ASSERT_IMPL(a_stall_only_on_term, i_clk, i_rst_n, o_in_stall, s_held_valid && s_held_term && o_out_valid && i_out_stall)

    // a loaded result shows up next cycle with a legal brightness
    `DSMP_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, s_res_load, o_out_valid && (o_new_bright <= BRIGHT_MAX))

endmodule

`default_nettype wire

@@ design/dsmp_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsmp_in_reg
    import dsmp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_fire,
    output logic       o_stall,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  s_accept;

    // held byte blocks a new transfer only when it cannot move on
    assign o_stall  = r_valid && !i_fire;
    assign s_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_accept) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ design/dsmp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsmp_parser
    import dsmp_pkg::*;
#(
    parameter int BUFFER_LEN = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_result    o_res
);

    localparam int PW = $clog2(BUFFER_LEN + 1);

    localparam logic [PW-1:0] POS_FULL      = PW'(BUFFER_LEN);
    localparam logic [PW-1:0] POS_CMD_FIRST = PW'(3);
    localparam logic [PW-1:0] POS_CMD_LAST  = PW'(9);
    localparam logic [PW-1:0] POS_BODY      = PW'(10);
    localparam logic [PW-1:0] POS_ARG_LAST  = PW'(14);
    localparam logic [PW-1:0] LEN_SHORT_CMD = PW'(9);
    localparam logic [PW-1:0] LEN_SETTING   = PW'(10);
    localparam logic [PW-1:0] POS_ONE       = PW'(1);

    localparam logic [3:0] KP_DONE    = 4'd15;
    localparam logic [3:0] KP_KEY_LEN = 4'd8;
    localparam logic [3:0] KP_ON_LEN  = 4'd4;
    localparam logic [2:0] ARG_FULL   = 3'd5;
    localparam logic [2:0] CMD_ALL    = 3'b111;
    localparam logic [2:0] RESULT_LEN = 3'd6;

    localparam int CM_RESULT  = 0;
    localparam int CM_UPDATE  = 1;
    localparam int CM_SETTING = 2;

    localparam logic [7:0] C_START  = 8'h41;
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_LOW_S  = 8'h73;
    localparam logic [7:0] C_LOW_B  = 8'h62;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] kp;
        t_key       key;
        logic [6:0] accum;
        logic       seen_sw;
        logic       psw;
        logic       seen_br;
        logic [6:0] pbr;
    } t_tok;

    localparam t_tok TOK_CLEAR = '{
        phase: PH_AWAIT_KEY, kp: 4'd0, key: KEY_NONE, accum: 7'd0,
        seen_sw: 1'b0, psw: 1'b0, seen_br: 1'b0, pbr: 7'd0
    };

    function automatic logic [7:0] result_ch(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = "R";
            3'd1:    ch = "E";
            3'd2:    ch = "S";
            3'd3:    ch = "U";
            3'd4:    ch = "L";
            3'd5:    ch = "T";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] update_ch(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = "U";
            3'd1:    ch = "P";
            3'd2:    ch = "D";
            3'd3:    ch = "A";
            3'd4:    ch = "T";
            3'd5:    ch = "E";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] setting_ch(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = "S";
            3'd1:    ch = "E";
            3'd2:    ch = "T";
            3'd3:    ch = "T";
            3'd4:    ch = "I";
            3'd5:    ch = "N";
            3'd6:    ch = "G";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] exit_ch(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = "=";
            3'd1:    ch = "e";
            3'd2:    ch = "x";
            3'd3:    ch = "i";
            3'd4:    ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] switch_ch(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = C_DQUOTE;
            3'd1:    ch = "s";
            3'd2:    ch = "w";
            3'd3:    ch = "i";
            3'd4:    ch = "t";
            3'd5:    ch = "c";
            3'd6:    ch = "h";
            default: ch = C_DQUOTE;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] bright_ch(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = C_DQUOTE;
            3'd1:    ch = "b";
            3'd2:    ch = "r";
            3'd3:    ch = "i";
            3'd4:    ch = "g";
            3'd5:    ch = "h";
            3'd6:    ch = "t";
            default: ch = C_DQUOTE;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] on_ch(input logic [1:0] i);
        logic [7:0] ch;
        unique case (i)
            2'd0:    ch = C_DQUOTE;
            2'd1:    ch = "o";
            2'd2:    ch = "n";
            default: ch = C_DQUOTE;
        endcase
        return ch;
    endfunction

    // a value that ends without "on" means off
    function automatic t_tok f_commit(input t_tok t);
        t_tok r;
        r = t;
        if (t.key == KEY_SWITCH) begin
            r.seen_sw = 1'b1;
            r.psw     = 1'b0;
        end else if (t.key == KEY_BRIGHT) begin
            r.seen_br = 1'b1;
            r.pbr     = t.accum;
        end
        r.key = KEY_NONE;
        return r;
    endfunction

    function automatic t_tok f_finish(input t_tok t);
        t_tok r;
        r = t;
        if (t.phase == PH_VALUE) begin
            r = f_commit(t);
        end
        r.phase = PH_AWAIT_KEY;
        r.key   = KEY_NONE;
        return r;
    endfunction

    function automatic t_tok f_key_char(input t_tok t, input logic [7:0] c);
        t_tok r;
        r = t;
        if (t.kp < KP_KEY_LEN) begin
            if (t.kp == 4'd0) begin
                if (c != C_DQUOTE) begin
                    r.key = KEY_NONE;
                end
            end else if (t.kp == 4'd1 && t.key == KEY_UNDECIDED) begin
                if (c == C_LOW_S) begin
                    r.key = KEY_SWITCH;
                end else if (c == C_LOW_B) begin
                    r.key = KEY_BRIGHT;
                end else begin
                    r.key = KEY_NONE;
                end
            end else if (t.key == KEY_SWITCH) begin
                if (c != switch_ch(t.kp[2:0])) begin
                    r.key = KEY_NONE;
                end
            end else if (t.key == KEY_BRIGHT) begin
                if (c != bright_ch(t.kp[2:0])) begin
                    r.key = KEY_NONE;
                end
            end
            r.kp = t.kp + 4'd1;
        end
        return r;
    endfunction

    function automatic t_tok f_value_char(input t_tok t, input logic [7:0] c);
        t_tok       r;
        logic [9:0] v;
        r = t;
        v = ({3'b000, t.accum} << 3) + ({3'b000, t.accum} << 1) + {6'd0, c[3:0]};
        if (t.key == KEY_SWITCH) begin
            if (t.kp < KP_ON_LEN && c == on_ch(t.kp[1:0])) begin
                r.kp = t.kp + 4'd1;
                if (r.kp == KP_ON_LEN) begin
                    r.seen_sw = 1'b1;
                    r.psw     = 1'b1;
                    r.key     = KEY_NONE;
                end
            end else begin
                r.seen_sw = 1'b1;
                r.psw     = 1'b0;
                r.key     = KEY_NONE;
            end
        end else if (t.key == KEY_BRIGHT) begin
            if (c >= C_ZERO && c <= C_NINE) begin
                // saturate at full brightness
                r.accum = (v > {3'b000, BRIGHT_MAX}) ? BRIGHT_MAX : v[6:0];
            end else begin
                r = f_commit(t);
            end
        end
        return r;
    endfunction

    function automatic t_tok f_body(input t_tok t, input logic [7:0] c);
        t_tok r;
        r = t;
        if (t.kp != KP_DONE) begin
            if (c == C_NUL) begin
                r    = f_finish(t);
                r.kp = KP_DONE;
            end else if (c == C_COMMA) begin
                r = f_finish(t);
            end else begin
                unique case (t.phase)
                    PH_AWAIT_KEY: begin
                        if (c != C_COLON) begin
                            r.phase = PH_KEY;
                            r.kp    = 4'd0;
                            r.key   = KEY_UNDECIDED;
                            r       = f_key_char(r, c);
                        end
                    end
                    PH_KEY: begin
                        if (c == C_COLON) begin
                            if (t.kp < KP_KEY_LEN) begin
                                r.key = KEY_NONE;
                            end
                            r.phase = PH_AWAIT_VAL;
                        end else begin
                            r = f_key_char(t, c);
                        end
                    end
                    PH_AWAIT_VAL: begin
                        if (c != C_COLON) begin
                            r.phase = PH_VALUE;
                            r.kp    = 4'd0;
                            r.accum = 7'd0;
                            r       = f_value_char(r, c);
                        end
                    end
                    PH_VALUE: begin
                        if (c == C_COLON) begin
                            r = f_commit(t);
                        end else begin
                            r = f_value_char(t, c);
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    logic [PW-1:0] r_byte_pos;
    logic [2:0]    r_cmd;
    logic [2:0]    r_arg;
    t_tok          r_tok;
    logic          r_settings;

    logic [PW-1:0] n_byte_pos;
    logic [2:0]    n_cmd;
    logic [2:0]    n_arg;
    t_tok          n_tok;
    logic          n_settings;

    logic [PW-1:0] s_pos;
    logic [PW-1:0] s_ofs_cmd;
    logic [PW-1:0] s_ofs_arg;
    t_tok          s_tok_end;
    logic [6:0]    s_cur_br;
    t_result       s_res;

    always_comb begin
        n_byte_pos = r_byte_pos;
        n_cmd      = r_cmd;
        n_arg      = r_arg;
        n_tok      = r_tok;
        n_settings = r_settings;
        s_pos      = r_byte_pos;
        s_ofs_cmd  = r_byte_pos - POS_CMD_FIRST;
        s_ofs_arg  = r_byte_pos - POS_BODY;
        s_tok_end  = r_tok;
        s_cur_br   = (i_item.cur_bright > BRIGHT_MAX) ? BRIGHT_MAX : i_item.cur_bright;

        s_res.msg_kind      = KIND_NONE;
        s_res.send_ok       = 1'b0;
        s_res.switch_change = 1'b0;
        s_res.new_switch    = i_item.cur_switch;
        s_res.bright_change = 1'b0;
        s_res.new_bright    = s_cur_br;

        if (i_fire && i_item.rx_byte != C_TERM) begin
            // full buffer drops the message
            if (r_byte_pos >= POS_FULL) begin
                n_byte_pos = '0;
                n_cmd      = '0;
                n_arg      = '0;
                n_tok      = TOK_CLEAR;
            end
            if (n_byte_pos != '0 || i_item.rx_byte == C_START) begin
                s_pos     = n_byte_pos;
                s_ofs_cmd = s_pos - POS_CMD_FIRST;
                s_ofs_arg = s_pos - POS_BODY;
                if (s_pos == '0) begin
                    n_cmd = CMD_ALL;
                    n_arg = '0;
                    n_tok = TOK_CLEAR;
                end
                if (s_pos >= POS_CMD_FIRST && s_pos <= POS_CMD_LAST) begin
                    if (s_ofs_cmd[2:0] < RESULT_LEN
                            && i_item.rx_byte != result_ch(s_ofs_cmd[2:0])) begin
                        n_cmd[CM_RESULT] = 1'b0;
                    end
                    if (s_ofs_cmd[2:0] < RESULT_LEN
                            && i_item.rx_byte != update_ch(s_ofs_cmd[2:0])) begin
                        n_cmd[CM_UPDATE] = 1'b0;
                    end
                    if (i_item.rx_byte != setting_ch(s_ofs_cmd[2:0])) begin
                        n_cmd[CM_SETTING] = 1'b0;
                    end
                end
                if (s_pos >= POS_BODY && s_pos <= POS_ARG_LAST) begin
                    if (n_arg == s_ofs_arg[2:0]
                            && i_item.rx_byte == exit_ch(s_ofs_arg[2:0])) begin
                        n_arg = n_arg + 3'd1;
                    end
                end
                if (s_pos >= POS_BODY) begin
                    n_tok = f_body(n_tok, i_item.rx_byte);
                end
                n_byte_pos = s_pos + POS_ONE;
            end
        end else if (i_fire) begin
            if (r_cmd[CM_RESULT] && r_byte_pos >= LEN_SHORT_CMD) begin
                s_res.msg_kind = KIND_RESULT;
            end else if (r_cmd[CM_UPDATE] && r_byte_pos >= LEN_SHORT_CMD) begin
                s_res.msg_kind = KIND_UPDATE;
                if (r_tok.kp != KP_DONE) begin
                    s_tok_end = f_finish(r_tok);
                end
                if (s_tok_end.seen_sw) begin
                    s_res.new_switch = s_tok_end.psw;
                end
                if (s_tok_end.seen_br) begin
                    s_res.new_bright = s_tok_end.pbr;
                end
                s_res.send_ok       = (s_res.new_bright == s_cur_br);
                s_res.switch_change = (s_res.new_switch != i_item.cur_switch);
                s_res.bright_change = (s_res.new_bright != s_cur_br);
            end else if (r_cmd[CM_SETTING] && r_byte_pos >= LEN_SETTING) begin
                if (r_arg == ARG_FULL) begin
                    n_settings     = 1'b0;
                    s_res.msg_kind = KIND_EXIT;
                end else if (!r_settings) begin
                    n_settings     = 1'b1;
                    s_res.msg_kind = KIND_ENTER;
                end
            end
            n_byte_pos = '0;
            n_cmd      = '0;
            n_arg      = '0;
            n_tok      = TOK_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_cmd      <= '0;
            r_arg      <= '0;
            r_tok      <= TOK_CLEAR;
            r_settings <= 1'b0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_cmd      <= n_cmd;
            r_arg      <= n_arg;
            r_tok      <= n_tok;
            r_settings <= n_settings;
        end
    end

    assign o_res = s_res;

endmodule

`default_nettype wire

@@ design/dsmp_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsmp_out_reg
    import dsmp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_stall,
    output logic         o_valid,
    output logic         o_busy,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // a held result that is not taken this cycle
    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire
